// File: design/program_sequencer_call_loop_stack_defines.svh
// Assertion macros used by the checker in pscls_checker.sv.
`ifndef PROGRAM_SEQUENCER_CALL_LOOP_STACK_DEFINES_SVH
`define PROGRAM_SEQUENCER_CALL_LOOP_STACK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PSCLS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define PSCLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

// File: design/pscls_pkg.sv
`timescale 1ns / 1ps

package pscls_pkg;

  localparam int CALL_DEPTH_DEF = 16;
  localparam int LOOP_DEPTH_DEF = 8;
  localparam int LINE_BITS_DEF  = 12;

  localparam int FIELD_LINE_W = 12;
  localparam int PLEN_W       = 13;
  localparam int VALUE_W      = 32;

  typedef enum logic [2:0] {
    MODE_PLAIN      = 3'd0,
    MODE_GOTO       = 3'd1,
    MODE_CALL       = 3'd2,
    MODE_RETURN     = 3'd3,
    MODE_COUNT_LOOP = 3'd4,
    MODE_ARRAY_LOOP = 3'd5,
    MODE_LOOP_END   = 3'd6,
    MODE_INVALID    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_RET_EMPTY  = 3'd1,
    ERR_LOOP_EMPTY = 3'd2,
    ERR_CALL_FULL  = 3'd3,
    ERR_LOOP_FULL  = 3'd4,
    ERR_INVALID    = 3'd5
  } err_t;

  typedef struct packed {
    logic [2:0]                     mode;
    logic [FIELD_LINE_W-1:0]        target_line;
    logic signed [VALUE_W-1:0]      first_value;
    logic signed [VALUE_W-1:0]      last_value;
    logic signed [VALUE_W-1:0]      step_value;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_LINE_W-1:0]        next_line;
    logic                           halted;
    logic                           stopped;
    logic [2:0]                     error_code;
    logic                           value_write;
    logic signed [VALUE_W-1:0]      loop_value;
  } out_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] current;
    logic signed [VALUE_W-1:0] limit;
    logic signed [VALUE_W-1:0] increment;
    logic                      over_array;
  } loop_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } call_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic update;
  } loop_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

endpackage

// File: design/pscls_call_stack.sv
`timescale 1ns / 1ps

module pscls_call_stack #(
  parameter int CALL_DEPTH = pscls_pkg::CALL_DEPTH_DEF,
  parameter int LINE_BITS  = pscls_pkg::LINE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pscls_pkg::call_ctl_t   ctl,
  input  logic [LINE_BITS-1:0]   push_line,
  output logic [LINE_BITS-1:0]   top_line,
  output pscls_pkg::stack_stat_t stat
);

  localparam int DEPTH_W = $clog2(CALL_DEPTH + 1);
  localparam int IDX_W   = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;

  logic [DEPTH_W-1:0]   depth;
  logic [DEPTH_W-1:0]   top_pos;
  logic [LINE_BITS-1:0] lines [CALL_DEPTH];

  assign top_pos    = depth - 1'b1;
  assign top_line   = lines[top_pos[IDX_W-1:0]];
  assign stat.empty = (depth == '0);
  assign stat.full  = (depth == DEPTH_W'(CALL_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctl.push) begin
      depth <= depth + 1'b1;
    end else if (ctl.pop) begin
      depth <= depth - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      lines[depth[IDX_W-1:0]] <= push_line;
    end
  end

endmodule

// File: design/pscls_loop_stack.sv
`timescale 1ns / 1ps

module pscls_loop_stack #(
  parameter int LOOP_DEPTH = pscls_pkg::LOOP_DEPTH_DEF,
  parameter int LINE_BITS  = pscls_pkg::LINE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pscls_pkg::loop_ctl_t                   ctl,
  input  pscls_pkg::loop_entry_t                 push_entry,
  input  logic [LINE_BITS-1:0]                   push_begin,
  input  logic signed [pscls_pkg::VALUE_W-1:0]   update_value,
  output pscls_pkg::loop_entry_t                 top_entry,
  output logic [LINE_BITS-1:0]                   top_begin,
  output pscls_pkg::stack_stat_t                 stat
);

  localparam int DEPTH_W = $clog2(LOOP_DEPTH + 1);
  localparam int IDX_W   = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;

  logic [DEPTH_W-1:0]     depth;
  logic [DEPTH_W-1:0]     top_pos;
  pscls_pkg::loop_entry_t entries [LOOP_DEPTH];
  logic [LINE_BITS-1:0]   begins  [LOOP_DEPTH];

  assign top_pos    = depth - 1'b1;
  assign top_entry  = entries[top_pos[IDX_W-1:0]];
  assign top_begin  = begins[top_pos[IDX_W-1:0]];
  assign stat.empty = (depth == '0);
  assign stat.full  = (depth == DEPTH_W'(LOOP_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctl.push) begin
      depth <= depth + 1'b1;
    end else if (ctl.pop) begin
      depth <= depth - 1'b1;
    end
  end

  // update rewrites the running value of the innermost loop
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entries[depth[IDX_W-1:0]] <= push_entry;
      begins[depth[IDX_W-1:0]]  <= push_begin;
    end else if (ctl.update) begin
      entries[top_pos[IDX_W-1:0]].current <= update_value;
    end
  end

endmodule

// File: design/pscls_exec.sv
`timescale 1ns / 1ps

module pscls_exec #(
  parameter int LINE_BITS = pscls_pkg::LINE_BITS_DEF
) (
  input  logic                                 active,
  input  pscls_pkg::in_item_t                  item,
  input  logic [LINE_BITS-1:0]                 line_counter,
  input  logic                                 stop_flag,
  input  logic [pscls_pkg::PLEN_W-1:0]         program_length,
  input  pscls_pkg::stack_stat_t               call_stat,
  input  logic [LINE_BITS-1:0]                 call_top_line,
  input  pscls_pkg::stack_stat_t               loop_stat,
  input  pscls_pkg::loop_entry_t               loop_top,
  input  logic [LINE_BITS-1:0]                 loop_top_begin,
  output logic [LINE_BITS-1:0]                 line_next,
  output logic                                 stop_next,
  output pscls_pkg::call_ctl_t                 call_ctl,
  output logic [LINE_BITS-1:0]                 call_push_line,
  output pscls_pkg::loop_ctl_t                 loop_ctl,
  output pscls_pkg::loop_entry_t               loop_push,
  output logic [LINE_BITS-1:0]                 loop_push_begin,
  output logic signed [pscls_pkg::VALUE_W-1:0] loop_update,
  output pscls_pkg::out_item_t                 result
);

  localparam int CMP_W = (LINE_BITS > pscls_pkg::PLEN_W) ? LINE_BITS : pscls_pkg::PLEN_W;
  localparam int OUT_W = pscls_pkg::FIELD_LINE_W;

  logic                                 run;
  logic [LINE_BITS-1:0]                 line_inc;
  logic [LINE_BITS-1:0]                 target;
  logic signed [pscls_pkg::VALUE_W-1:0] incr;
  logic signed [pscls_pkg::VALUE_W-1:0] stepped;
  logic                                 done;
  logic                                 vw;
  logic signed [pscls_pkg::VALUE_W-1:0] val;
  pscls_pkg::err_t                      err;

  assign run      = active && !stop_flag &&
                    (CMP_W'(line_counter) < CMP_W'(program_length));
  assign line_inc = line_counter + 1'b1;
  assign target   = LINE_BITS'(item.target_line);

  // loop end: array loops step by one and test before the step
  assign incr    = loop_top.over_array ? 32'sd1 : loop_top.increment;
  assign stepped = loop_top.current + incr;
  assign done    = loop_top.over_array ? (loop_top.current >= loop_top.limit)
                                       : (stepped >= loop_top.limit);

  assign call_push_line  = line_inc;
  assign loop_push_begin = line_inc;
  assign loop_update     = stepped;

  always_comb begin
    loop_push.over_array = (item.mode == pscls_pkg::MODE_ARRAY_LOOP);
    loop_push.current    = loop_push.over_array ? '0 : item.first_value;
    loop_push.limit      = item.last_value;
    loop_push.increment  = loop_push.over_array ? 32'sd1 : item.step_value;
  end

  always_comb begin
    line_next = line_counter;
    err       = pscls_pkg::ERR_NONE;
    vw        = 1'b0;
    val       = '0;
    call_ctl  = '0;
    loop_ctl  = '0;
    if (run) begin
      unique case (item.mode)
        pscls_pkg::MODE_PLAIN: begin
          line_next = line_inc;
        end
        pscls_pkg::MODE_GOTO: begin
          line_next = target;
        end
        pscls_pkg::MODE_CALL: begin
          if (call_stat.full) begin
            err = pscls_pkg::ERR_CALL_FULL;
          end else begin
            call_ctl.push = 1'b1;
            line_next     = target;
          end
        end
        pscls_pkg::MODE_RETURN: begin
          if (call_stat.empty) begin
            err = pscls_pkg::ERR_RET_EMPTY;
          end else begin
            call_ctl.pop = 1'b1;
            line_next    = call_top_line;
          end
        end
        pscls_pkg::MODE_COUNT_LOOP, pscls_pkg::MODE_ARRAY_LOOP: begin
          if (loop_stat.full) begin
            err = pscls_pkg::ERR_LOOP_FULL;
          end else begin
            loop_ctl.push = 1'b1;
            line_next     = line_inc;
            vw            = 1'b1;
            val           = loop_push.current;
          end
        end
        pscls_pkg::MODE_LOOP_END: begin
          if (loop_stat.empty) begin
            err = pscls_pkg::ERR_LOOP_EMPTY;
          end else if (done) begin
            loop_ctl.pop = 1'b1;
            line_next    = line_inc;
          end else begin
            loop_ctl.update = 1'b1;
            line_next       = loop_top_begin;
            vw              = 1'b1;
            val             = stepped;
          end
        end
        default: begin
          err = pscls_pkg::ERR_INVALID;
        end
      endcase
    end
  end

  assign stop_next = stop_flag || (err != pscls_pkg::ERR_NONE);

  always_comb begin
    result.next_line   = OUT_W'(line_next);
    result.halted      = (CMP_W'(line_next) >= CMP_W'(program_length));
    result.stopped     = stop_next;
    result.error_code  = err;
    result.value_write = vw;
    result.loop_value  = val;
  end

endmodule

// File: design/program_sequencer_call_loop_stack.sv
`timescale 1ns / 1ps
// Path: input register, then execute into the result register once free or draining.
// Throughput: one item per cycle while rsp_stall is low; the loop-end add and signed
//   compare on the loop stack top, plus the stack top read, close in the execute stage.
// Reset: synchronous on rst; clears counter, stop flag, stack depths, program_length
//   and both valid bits. Stack contents are not cleared; no clearing pass.

module program_sequencer_call_loop_stack #(
  parameter int CALL_DEPTH = pscls_pkg::CALL_DEPTH_DEF,
  parameter int LOOP_DEPTH = pscls_pkg::LOOP_DEPTH_DEF,
  parameter int LINE_BITS  = pscls_pkg::LINE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // command items, one per executed line
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  pscls_pkg::in_item_t          cmd,
  // result items
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output pscls_pkg::out_item_t         rsp,
  // program_length write port
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pscls_pkg::PLEN_W-1:0] cfg_data
);

  // input register
  logic                                 ireg_valid;
  pscls_pkg::in_item_t                  ireg;

  // architectural state
  logic [LINE_BITS-1:0]                 line_counter;
  logic                                 stop_flag;
  logic [pscls_pkg::PLEN_W-1:0]         program_length;

  // execute-stage wiring
  logic                                 fire;
  logic [LINE_BITS-1:0]                 line_next;
  logic                                 stop_next;
  pscls_pkg::call_ctl_t                 call_ctl;
  pscls_pkg::stack_stat_t               call_stat;
  logic [LINE_BITS-1:0]                 call_push_line;
  logic [LINE_BITS-1:0]                 call_top_line;
  pscls_pkg::loop_ctl_t                 loop_ctl;
  pscls_pkg::stack_stat_t               loop_stat;
  pscls_pkg::loop_entry_t               loop_push;
  pscls_pkg::loop_entry_t               loop_top;
  logic [LINE_BITS-1:0]                 loop_push_begin;
  logic [LINE_BITS-1:0]                 loop_top_begin;
  logic signed [pscls_pkg::VALUE_W-1:0] loop_update;
  pscls_pkg::out_item_t                 result;

  // The held item executes whenever the result register is free or being drained.
  // All state (counter, stop flag, stacks) commits on that same edge, so the next
  // item in the input register already sees it.
  assign fire      = ireg_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = ireg_valid && !fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid     <= 1'b0;
      rsp_valid      <= 1'b0;
      line_counter   <= '0;
      stop_flag      <= 1'b0;
      program_length <= '0;
    end else begin
      if (!cmd_stall) begin
        ireg_valid <= cmd_valid;
      end
      if (fire) begin
        rsp_valid    <= 1'b1;
        line_counter <= line_next;
        stop_flag    <= stop_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        program_length <= cfg_data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      ireg <= cmd;
    end
    if (fire) begin
      rsp <= result;
    end
  end

  // return-line stack
  pscls_call_stack #(
    .CALL_DEPTH (CALL_DEPTH),
    .LINE_BITS  (LINE_BITS)
  ) u_call_stack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (call_ctl),
    .push_line (call_push_line),
    .top_line  (call_top_line),
    .stat      (call_stat)
  );

  // loop-entry stack
  pscls_loop_stack #(
    .LOOP_DEPTH (LOOP_DEPTH),
    .LINE_BITS  (LINE_BITS)
  ) u_loop_stack (
    .clk          (clk),
    .rst          (rst),
    .ctl          (loop_ctl),
    .push_entry   (loop_push),
    .push_begin   (loop_push_begin),
    .update_value (loop_update),
    .top_entry    (loop_top),
    .top_begin    (loop_top_begin),
    .stat         (loop_stat)
  );

  // decode and next-state logic; stack controls are gated by fire inside
  pscls_exec #(
    .LINE_BITS (LINE_BITS)
  ) u_exec (
    .active          (fire),
    .item            (ireg),
    .line_counter    (line_counter),
    .stop_flag       (stop_flag),
    .program_length  (program_length),
    .call_stat       (call_stat),
    .call_top_line   (call_top_line),
    .loop_stat       (loop_stat),
    .loop_top        (loop_top),
    .loop_top_begin  (loop_top_begin),
    .line_next       (line_next),
    .stop_next       (stop_next),
    .call_ctl        (call_ctl),
    .call_push_line  (call_push_line),
    .loop_ctl        (loop_ctl),
    .loop_push       (loop_push),
    .loop_push_begin (loop_push_begin),
    .loop_update     (loop_update),
    .result          (result)
  );

endmodule

// File: design/pscls_checker.sv
`timescale 1ns / 1ps
`include "program_sequencer_call_loop_stack_defines.svh"

module pscls_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input pscls_pkg::out_item_t rsp
);

  // stalled result holds
  `PSCLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // once stopped, every later result stays stopped
  `PSCLS_ASSERT_NEXT(a_stop_sticky, rsp_valid && rsp.stopped, !rsp_valid || rsp.stopped)

  // an error always stops and never writes a loop value
  `PSCLS_ASSERT_NOW(a_err_stops, rsp_valid && (rsp.error_code != pscls_pkg::ERR_NONE), rsp.stopped && !rsp.value_write)

  // no value write means a zero value
  `PSCLS_ASSERT_NOW(a_value_zero, rsp_valid && !rsp.value_write, rsp.loop_value == 32'sd0)

endmodule

bind program_sequencer_call_loop_stack pscls_checker u_checker (.*);

// File: sim/program_sequencer_call_loop_stack_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and length-write channels, predicts each result
// and compares it with what the sequencer returns.
module program_sequencer_call_loop_stack_checker #(
  parameter int CALL_DEPTH = pscls_pkg::CALL_DEPTH_DEF,
  parameter int LOOP_DEPTH = pscls_pkg::LOOP_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  input  logic                               cmd_stall,
  input  pscls_pkg::in_item_t                cmd,
  input  logic                               rsp_valid,
  input  logic                               rsp_stall,
  input  pscls_pkg::out_item_t               rsp,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [pscls_pkg::PLEN_W-1:0]       cfg_data,
  output int                                 fail_count,
  output int                                 pending,
  output logic [pscls_pkg::FIELD_LINE_W-1:0] line_now,
  output logic                               halted_now,
  output int                                 call_depth_now,
  output int                                 loop_depth_now
);

  logic [pscls_pkg::FIELD_LINE_W-1:0] pc;
  logic                               stop_flag;
  logic [pscls_pkg::PLEN_W-1:0]       prog_len;
  logic [pscls_pkg::FIELD_LINE_W-1:0] ret_line [CALL_DEPTH];
  int                                 ret_depth;
  logic [pscls_pkg::FIELD_LINE_W-1:0] loop_begin [LOOP_DEPTH];
  logic signed [31:0]                 loop_cur [LOOP_DEPTH];
  logic signed [31:0]                 loop_lim [LOOP_DEPTH];
  logic signed [31:0]                 loop_inc [LOOP_DEPTH];
  logic                               loop_arr [LOOP_DEPTH];
  int                                 loop_depth;
  pscls_pkg::out_item_t               expected_rsp [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  assign line_now       = pc;
  assign halted_now     = ({1'b0, pc} >= prog_len);
  assign call_depth_now = ret_depth;
  assign loop_depth_now = loop_depth;

  // One executed line: updates the shadow state, returns the expected item.
  function automatic pscls_pkg::out_item_t execute_line(pscls_pkg::in_item_t it);
    pscls_pkg::out_item_t r;
    logic signed [31:0]   nxt;
    logic                 done;
    int                   t;
    r = '0;
    r.error_code = pscls_pkg::ERR_NONE;
    if (!stop_flag && ({1'b0, pc} < prog_len)) begin
      case (it.mode)
        pscls_pkg::MODE_PLAIN: pc = pc + 1'b1;
        pscls_pkg::MODE_GOTO:  pc = it.target_line;
        pscls_pkg::MODE_CALL: begin
          if (ret_depth >= CALL_DEPTH) begin
            r.error_code = pscls_pkg::ERR_CALL_FULL;
          end else begin
            ret_line[ret_depth] = pc + 1'b1;
            ret_depth++;
            pc = it.target_line;
          end
        end
        pscls_pkg::MODE_RETURN: begin
          if (ret_depth == 0) begin
            r.error_code = pscls_pkg::ERR_RET_EMPTY;
          end else begin
            ret_depth--;
            pc = ret_line[ret_depth];
          end
        end
        pscls_pkg::MODE_COUNT_LOOP, pscls_pkg::MODE_ARRAY_LOOP: begin
          if (loop_depth >= LOOP_DEPTH) begin
            r.error_code = pscls_pkg::ERR_LOOP_FULL;
          end else begin
            t = loop_depth;
            loop_arr[t]   = (it.mode == pscls_pkg::MODE_ARRAY_LOOP);
            loop_begin[t] = pc + 1'b1;
            loop_cur[t]   = loop_arr[t] ? 32'sd0 : it.first_value;
            loop_lim[t]   = it.last_value;
            loop_inc[t]   = loop_arr[t] ? 32'sd1 : it.step_value;
            loop_depth++;
            pc = pc + 1'b1;
            r.value_write = 1'b1;
            r.loop_value  = loop_cur[t];
          end
        end
        pscls_pkg::MODE_LOOP_END: begin
          if (loop_depth == 0) begin
            r.error_code = pscls_pkg::ERR_LOOP_EMPTY;
          end else begin
            t = loop_depth - 1;
            if (loop_arr[t]) begin
              done = (loop_cur[t] >= loop_lim[t]);
              nxt  = loop_cur[t] + 32'sd1;
            end else begin
              nxt  = loop_cur[t] + loop_inc[t];
              done = (nxt >= loop_lim[t]);
            end
            if (done) begin
              loop_depth = t;
              pc = pc + 1'b1;
            end else begin
              loop_cur[t]   = nxt;
              r.value_write = 1'b1;
              r.loop_value  = nxt;
              pc = loop_begin[t];
            end
          end
        end
        default: r.error_code = pscls_pkg::ERR_INVALID;
      endcase
      if (r.error_code != pscls_pkg::ERR_NONE) stop_flag = 1'b1;
    end
    r.next_line = pc;
    r.halted    = ({1'b0, pc} >= prog_len);
    r.stopped   = stop_flag;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    pscls_pkg::out_item_t want;
    pscls_pkg::out_item_t pred;
    if (rst) begin
      pc         = '0;
      stop_flag  = 1'b0;
      prog_len   = '0;
      ret_depth  = 0;
      loop_depth = 0;
      expected_rsp.delete();
    end else begin
      // results first: an item taken at this edge cannot have its result yet
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("next_line", 32'(want.next_line), 32'(rsp.next_line));
          check_field("halted", 32'(want.halted), 32'(rsp.halted));
          check_field("stopped", 32'(want.stopped), 32'(rsp.stopped));
          check_field("error_code", 32'(want.error_code), 32'(rsp.error_code));
          check_field("value_write", 32'(want.value_write), 32'(rsp.value_write));
          check_field("loop_value", want.loop_value, rsp.loop_value);
        end
      end
      if (cfg_valid && cfg_ready) prog_len = cfg_data;
      if (cmd_valid && !cmd_stall) begin
        pred = execute_line(cmd);
        expected_rsp = {expected_rsp, pred};
      end
    end
    pending = expected_rsp.size();
  end

endmodule

// File: sim/tb_program_sequencer_call_loop_stack.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the program sequencer. The checker beside the
// block does all prediction and comparison; this module drives items, lengths and stalls.
module tb_program_sequencer_call_loop_stack;

  localparam int RANDOM_ITEMS   = 1900;
  localparam int MAX_GAP        = 10;
  localparam int PROG_LINES_MAX = 4096;
  localparam int HOLD_AFTER     = 300;    // results seen before the long hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 4;      // settle margin after the last expected result
  localparam int CYCLE_LIMIT    = 500000;

  logic                               clk;
  logic                               rst;
  logic                               cmd_valid;
  logic                               cmd_stall;
  pscls_pkg::in_item_t                cmd;
  logic                               rsp_valid;
  logic                               rsp_stall;
  pscls_pkg::out_item_t               rsp;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [pscls_pkg::PLEN_W-1:0]       cfg_data;

  // checker outputs: failures, pending results and predicted state for the stimulus
  int                                 fail_count;
  int                                 pending;
  logic [pscls_pkg::FIELD_LINE_W-1:0] line_now;
  logic                               halted_now;
  int                                 call_depth_now;
  int                                 loop_depth_now;

  int                                 cur_len;       // program length last written
  logic                               tx_calm;       // sender runs back to back
  logic                               rx_calm;       // receiver adds no random hold-off
  int                                 cycles;

  program_sequencer_call_loop_stack uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  program_sequencer_call_loop_stack_checker seq_chk (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .cmd            (cmd),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .line_now       (line_now),
    .halted_now     (halted_now),
    .call_depth_now (call_depth_now),
    .loop_depth_now (loop_depth_now)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: a hang anywhere (lost result, stuck stall) ends here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side. Each item gets a random hold-off, some stretches none, and
  // once a long hold-off while the sender keeps pushing, so the block backs
  // up and stalls its input.
  initial begin : receiver
    int w;
    int got;
    rsp_stall = 1'b0;
    rx_calm   = 1'b0;
    got       = 0;
    wait (!rst);
    forever begin
      w = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (got == HOLD_AFTER) w = HOLD_CYCLES;
      if (w > 0) begin
        rsp_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      rsp_stall = 1'b0;
      do @(posedge clk); while (!rsp_valid);
      got++;
      if (got % 97 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item
  // was taken, so the predicted state is settled for the next choice.
  // Valid stays high across back-to-back items.
  task automatic issue(input pscls_pkg::in_item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd       = it;
    cmd_valid = 1'b1;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  task automatic put(input pscls_pkg::mode_t m, input int tgt, input logic [31:0] first,
                     input logic [31:0] last, input logic [31:0] step);
    pscls_pkg::in_item_t it;
    it.mode        = m;
    it.target_line = tgt[pscls_pkg::FIELD_LINE_W-1:0];
    it.first_value = first;
    it.last_value  = last;
    it.step_value  = step;
    issue(it);
  endtask

  // Length writes only with the block idle: drop valid, drain, then write.
  task automatic write_length(input int len);
    cmd_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = len[pscls_pkg::PLEN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_len   = len;
  endtask

  // Mostly well-formed control flow: stack ops only where they cannot
  // fault (a fault is sticky and would end the run's useful part), loops
  // that always terminate, targets mostly inside the program.
  function automatic pscls_pkg::in_item_t random_op();
    pscls_pkg::in_item_t it;
    int                  pick;
    logic [31:0]         a, b, c;
    it.target_line = pscls_pkg::FIELD_LINE_W'($urandom);
    if (cur_len > 0 && $urandom_range(0, 9) != 0)
      it.target_line = pscls_pkg::FIELD_LINE_W'($urandom_range(0, cur_len - 1));
    // count loop fields
    if ($urandom_range(0, 4) == 0) begin
      // any values; limit pulled down so the first loop end exits
      a = $urandom;
      b = $urandom;
      c = $urandom;
      if ($signed(b) > $signed(a + c)) b = a + c;
    end else begin
      a = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64) - 32;
      c = $urandom_range(1, 4);
      b = a + c * $urandom_range(0, 4);
    end
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.mode = pscls_pkg::MODE_PLAIN;
    end else if (pick < 35) begin
      it.mode = pscls_pkg::MODE_GOTO;
    end else if (pick < 50) begin
      it.mode = (call_depth_now < pscls_pkg::CALL_DEPTH_DEF) ? pscls_pkg::MODE_CALL
                                                             : pscls_pkg::MODE_RETURN;
    end else if (pick < 65) begin
      it.mode = (call_depth_now > 0) ? pscls_pkg::MODE_RETURN : pscls_pkg::MODE_CALL;
    end else if (pick < 75) begin
      it.mode = (loop_depth_now < pscls_pkg::LOOP_DEPTH_DEF) ? pscls_pkg::MODE_COUNT_LOOP
                                                             : pscls_pkg::MODE_LOOP_END;
    end else if (pick < 82) begin
      it.mode = (loop_depth_now < pscls_pkg::LOOP_DEPTH_DEF) ? pscls_pkg::MODE_ARRAY_LOOP
                                                             : pscls_pkg::MODE_LOOP_END;
      // array bound: short, or negative so it exits at once
      b = ($urandom_range(0, 4) == 0) ? {1'b1, 31'($urandom)} : $urandom_range(0, 4);
    end else begin
      it.mode = (loop_depth_now > 0) ? pscls_pkg::MODE_LOOP_END
                                     : pscls_pkg::MODE_COUNT_LOOP;
    end
    it.first_value = a;
    it.last_value  = b;
    it.step_value  = c;
    return it;
  endfunction

  initial begin : stimulus
    int              counted;
    int              span;
    int              quiet;
    int              k;
    int              len;
    int              pick;
    pscls_pkg::err_t fault;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    cur_len   = 0;
    tx_calm   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // program length is zero out of reset: everything is halted
    put(pscls_pkg::MODE_PLAIN, 0, 0, 0, 0);
    put(pscls_pkg::MODE_CALL, 7, 0, 0, 0);

    // ---- directed part, full-size program so nothing halts ----
    write_length(PROG_LINES_MAX);
    put(pscls_pkg::MODE_PLAIN, 0, 0, 0, 0);
    put(pscls_pkg::MODE_GOTO, 4095, 0, 0, 0);
    put(pscls_pkg::MODE_PLAIN, 0, 0, 0, 0);                  // counter wraps to 0
    put(pscls_pkg::MODE_GOTO, 4095, 0, 0, 0);
    put(pscls_pkg::MODE_CALL, 0, 0, 0, 0);                   // return line wraps to 0
    put(pscls_pkg::MODE_RETURN, 0, 0, 0, 0);
    put(pscls_pkg::MODE_CALL, 100, 0, 0, 0);
    put(pscls_pkg::MODE_RETURN, 0, 0, 0, 0);
    // value wrap: max + 1 goes negative, branches once, then exits
    put(pscls_pkg::MODE_COUNT_LOOP, 0, 32'h7FFF_FFFF, 32'h8000_0001, 32'd1);
    put(pscls_pkg::MODE_LOOP_END, 0, 0, 0, 0);
    put(pscls_pkg::MODE_LOOP_END, 0, 0, 0, 0);
    // array loop over three elements
    put(pscls_pkg::MODE_ARRAY_LOOP, 0, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF);
    put(pscls_pkg::MODE_LOOP_END, 0, 0, 0, 0);
    put(pscls_pkg::MODE_LOOP_END, 0, 0, 0, 0);
    put(pscls_pkg::MODE_LOOP_END, 0, 0, 0, 0);
    // negative step, exits at the first end
    put(pscls_pkg::MODE_COUNT_LOOP, 0, -32'sd5, -32'sd20, -32'sd3);
    put(pscls_pkg::MODE_LOOP_END, 0, 0, 0, 0);
    // extreme fields: min start, max step, limit -1
    put(pscls_pkg::MODE_COUNT_LOOP, 4095, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    put(pscls_pkg::MODE_LOOP_END, 0, 0, 0, 0);
    // array with negative bound, zero step count loop
    put(pscls_pkg::MODE_ARRAY_LOOP, 0, 0, 32'h8000_0000, 0);
    put(pscls_pkg::MODE_LOOP_END, 0, 0, 0, 0);
    put(pscls_pkg::MODE_COUNT_LOOP, 0, 32'd3, 32'd3, 32'd0);
    put(pscls_pkg::MODE_LOOP_END, 0, 0, 0, 0);
    put(pscls_pkg::MODE_GOTO, 0, 0, 0, 0);
    // one-line program: one step halts, next item is ignored
    write_length(1);
    put(pscls_pkg::MODE_PLAIN, 0, 0, 0, 0);
    put(pscls_pkg::MODE_GOTO, 5, 0, 0, 0);

    // ---- random phases, each with its own program length ----
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 7);
      if (pick == 0)      len = PROG_LINES_MAX;
      else if (pick == 1) len = int'(line_now) + 1;
      else if (pick == 2) len = $urandom_range(0, line_now);   // start halted
      else                len = $urandom_range(int'(line_now) + 1, PROG_LINES_MAX);
      write_length(len);
      tx_calm = ($urandom_range(0, 3) == 0);
      span    = $urandom_range(20, 250);
      quiet   = 0;
      // a phase ends after a few halted items; those do not count
      for (k = 0; k < span && quiet < 3; k++) begin
        if (halted_now) quiet++;
        else counted++;
        issue(random_op());
      end
    end

    // ---- one fault to close the run (the stop flag is sticky) ----
    write_length(PROG_LINES_MAX);
    tx_calm = 1'b0;
    fault   = pscls_pkg::err_t'(3'($urandom_range(1, 5)));
    case (fault)
      pscls_pkg::ERR_RET_EMPTY: begin
        while (call_depth_now > 0) put(pscls_pkg::MODE_RETURN, 0, 0, 0, 0);
        put(pscls_pkg::MODE_RETURN, 0, 0, 0, 0);
      end
      pscls_pkg::ERR_CALL_FULL: begin
        while (call_depth_now < pscls_pkg::CALL_DEPTH_DEF)
          put(pscls_pkg::MODE_CALL, $urandom, 0, 0, 0);
        put(pscls_pkg::MODE_CALL, $urandom, 0, 0, 0);
      end
      pscls_pkg::ERR_LOOP_FULL: begin
        while (loop_depth_now < pscls_pkg::LOOP_DEPTH_DEF)
          put(pscls_pkg::MODE_ARRAY_LOOP, 0, 0, 0, 0);
        put(pscls_pkg::MODE_COUNT_LOOP, 0, $urandom, $urandom, $urandom);
      end
      pscls_pkg::ERR_LOOP_EMPTY: begin
        // every loop here terminates; cap the unwinding anyway
        for (k = 0; k < 64 && loop_depth_now > 0; k++)
          put(pscls_pkg::MODE_LOOP_END, 0, 0, 0, 0);
        put((loop_depth_now == 0) ? pscls_pkg::MODE_LOOP_END : pscls_pkg::MODE_INVALID,
            0, 0, 0, 0);
      end
      default: put(pscls_pkg::MODE_INVALID, $urandom, $urandom, $urandom, $urandom);
    endcase
    // stopped: nothing changes any more, no further error codes
    for (k = 0; k < 4; k++) issue(random_op());
    put(pscls_pkg::MODE_INVALID, 0, 0, 0, 0);

    // drain and decide
    cmd_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
